### sv/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types and constants for decimal scale alignment: sequencer states,
// datapath operations, control and status groups, divide-by-ten reciprocal.
// ----------------------------------------------------------------------------
package dsa_pkg;

   localparam int MANT_BITS_DEF = 96;
   localparam int IN_MANT_BITS  = 96;
   localparam int LOW_BITS      = 64;
   localparam int HIGH_BITS     = 32;
   localparam int SCALE_BITS    = 8;
   localparam int LIMB_BITS     = 32;
   localparam int REM_BITS      = 4;
   localparam int DIV_IN_BITS   = LIMB_BITS + REM_BITS;

   // floor(v / 10) = (v * RECIP_M) >> RECIP_SHIFT for every v below 10 * 2^32
   localparam int                RECIP_SHIFT = 38;
   localparam int                RECIP_BITS  = 35;
   localparam logic [RECIP_BITS-1:0] RECIP_M = 35'd27487790695;
   localparam int                PROD_BITS   = DIV_IN_BITS + RECIP_BITS;

   localparam logic [REM_BITS-1:0] ROUND_DIGIT = 4'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_DOWN,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_LOAD,
      OP_MUL,
      OP_UP_SKIP,
      OP_DIV,
      OP_DOWN_SKIP,
      OP_INC
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [SCALE_BITS-1:0] count;
      logic                  div_first;
      logic                  div_last;
      logic                  sel_inc;
      logic                  busy;
      logic                  done;
   } ctl_type;

   typedef struct packed {
      logic                up_zero;
      logic                up_stop;
      logic                down_zero;
      logic [REM_BITS-1:0] rem;
   } stat_type;

endpackage

### sv/dsa_alu.sv
// ----------------------------------------------------------------------------
// dsa_alu
// Shared arithmetic unit: one wide adder for times ten or increment, and a
// one-limb divide by ten with remainder.
// ----------------------------------------------------------------------------
module dsa_alu #(
   parameter int MANT_BITS = dsa_pkg::MANT_BITS_DEF
) (
   input  logic                          sel_inc,
   input  logic [MANT_BITS-1:0]          operand,
   input  logic [dsa_pkg::LIMB_BITS-1:0] limb,
   input  logic [dsa_pkg::REM_BITS-1:0]  rem_in,
   output logic [MANT_BITS+3:0]          sum,
   output logic [dsa_pkg::LIMB_BITS-1:0] quot,
   output logic [dsa_pkg::REM_BITS-1:0]  rem_out
);
   import dsa_pkg::*;

   localparam int SUM_BITS = MANT_BITS + 4;

   logic [SUM_BITS-1:0]    add_a;
   logic [SUM_BITS-1:0]    add_b;
   logic [DIV_IN_BITS-1:0] div_in;
   logic [PROD_BITS-1:0]   prod;
   logic [REM_BITS-1:0]    q_times_ten;

   // x*10 as (x<<3)+(x<<1), or x+1
   always_comb begin
      if (sel_inc) begin
         add_a = SUM_BITS'(operand);
         add_b = SUM_BITS'(1);
      end else begin
         add_a = SUM_BITS'(operand) << 3;
         add_b = SUM_BITS'(operand) << 1;
      end
   end

   assign sum = add_a + add_b;

   assign div_in      = {rem_in, limb};
   assign prod        = PROD_BITS'(div_in) * PROD_BITS'(RECIP_M);
   assign quot        = prod[RECIP_SHIFT +: LIMB_BITS];
   assign q_times_ten = {quot[0], 3'b000} + {quot[2:0], 1'b0};
   assign rem_out     = div_in[REM_BITS-1:0] - q_times_ten;

endmodule

### sv/dsa_seq.sv
// ----------------------------------------------------------------------------
// dsa_seq
// Sequencer: step count, limb index and dropped-digit flag; chooses the
// operation of the shared unit in each cycle.
// ----------------------------------------------------------------------------
module dsa_seq #(
   parameter int MANT_BITS = dsa_pkg::MANT_BITS_DEF,
   parameter int LIMB_CNT  = (MANT_BITS + dsa_pkg::LIMB_BITS - 1) / dsa_pkg::LIMB_BITS,
   parameter int IDX_BITS  = (LIMB_CNT > 1) ? $clog2(LIMB_CNT) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [dsa_pkg::SCALE_BITS-1:0] load_count,
   input  dsa_pkg::stat_type              stat,
   output dsa_pkg::ctl_type               ctl,
   output logic [IDX_BITS-1:0]            limb_idx
);
   import dsa_pkg::*;

   localparam logic [IDX_BITS-1:0] LIMB_TOP = IDX_BITS'(LIMB_CNT - 1);

   state_type             state_ff, state_in;
   logic [SCALE_BITS-1:0] count_ff, count_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  dropped_ff, dropped_in;
   op_type                op;
   logic                  div_first;
   logic                  div_last;
   logic                  round_up;

   assign div_first = (idx_ff == LIMB_TOP);
   assign div_last  = (idx_ff == '0);
   assign round_up  = div_last && (count_ff == SCALE_BITS'(1)) &&
                      (stat.rem >= ROUND_DIGIT) && dropped_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_UP;
         end
         ST_UP: begin
            if (count_ff == '0 || stat.up_zero) state_in = ST_DONE;
            else if (stat.up_stop)              state_in = ST_DOWN;
         end
         ST_DOWN: begin
            if (count_ff == '0 || (div_first && stat.down_zero)) state_in = ST_DONE;
            else if (round_up)                                    state_in = ST_ROUND;
         end
         ST_ROUND: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // operation of the shared unit
   always_comb begin
      op = OP_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (accept) op = OP_LOAD;
         end
         ST_UP: begin
            if (count_ff == '0)    op = OP_IDLE;
            else if (stat.up_zero) op = OP_UP_SKIP;
            else if (stat.up_stop) op = OP_IDLE;
            else                   op = OP_MUL;
         end
         ST_DOWN: begin
            if (count_ff == '0)                      op = OP_IDLE;
            else if (div_first && stat.down_zero)    op = OP_DOWN_SKIP;
            else                                     op = OP_DIV;
         end
         ST_ROUND: op = OP_INC;
         default:  op = OP_IDLE;
      endcase
   end

   // step count, limb index, dropped digit
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      dropped_in = dropped_ff;
      case (op)
         OP_LOAD: begin
            count_in   = load_count;
            idx_in     = LIMB_TOP;
            dropped_in = 1'b0;
         end
         OP_MUL:       count_in = count_ff - SCALE_BITS'(1);
         OP_UP_SKIP:   count_in = '0;
         OP_DOWN_SKIP: count_in = '0;
         OP_DIV: begin
            if (div_last) begin
               count_in = count_ff - SCALE_BITS'(1);
               idx_in   = LIMB_TOP;
               if (stat.rem != '0 && count_ff > SCALE_BITS'(1)) dropped_in = 1'b1;
            end else begin
               idx_in = idx_ff - IDX_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         idx_ff     <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         dropped_ff <= dropped_in;
      end
   end

   assign ctl.op        = op;
   assign ctl.count     = count_ff;
   assign ctl.div_first = div_first;
   assign ctl.div_last  = div_last;
   assign ctl.sel_inc   = (state_ff == ST_ROUND);
   assign ctl.busy      = (state_ff != ST_IDLE);
   assign ctl.done      = (state_ff == ST_DONE);
   assign limb_idx      = idx_ff;

endmodule

### sv/decimal_scale_alignment.sv
// ----------------------------------------------------------------------------
// decimal_scale_alignment
// Brings two sign-magnitude decimals to a common scale: the smaller-scale
// operand is multiplied by ten, then the other is divided by ten with rounding.
// ----------------------------------------------------------------------------
// rsp_valid strobes once the scales meet or the up operand is zero, else once the down
//   operand has been divided or found zero; there are at most 28 multiply-by-ten steps
//   and at most 29 divisions of a nonzero mantissa, each over LIMB_CNT limbs (LIMB_CNT = 3
//   at 96 bits); a round-up takes the place of the closing down cycle
// a new item is accepted only while busy is low; busy stays high through the strobe cycle
// reset returns the sequencer to idle; no item is pending after reset
module decimal_scale_alignment #(
   parameter int MANT_BITS = dsa_pkg::MANT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dsa_pkg::LOW_BITS-1:0]   req_a_mant_low,
   input  logic [dsa_pkg::HIGH_BITS-1:0]  req_a_mant_high,
   input  logic [dsa_pkg::SCALE_BITS-1:0] req_a_scale,
   input  logic                           req_a_negative,
   input  logic [dsa_pkg::LOW_BITS-1:0]   req_b_mant_low,
   input  logic [dsa_pkg::HIGH_BITS-1:0]  req_b_mant_high,
   input  logic [dsa_pkg::SCALE_BITS-1:0] req_b_scale,
   input  logic                           req_b_negative,
   output logic                           rsp_valid,
   output logic [dsa_pkg::LOW_BITS-1:0]   rsp_a_out_low,
   output logic [dsa_pkg::HIGH_BITS-1:0]  rsp_a_out_high,
   output logic [dsa_pkg::SCALE_BITS-1:0] rsp_a_out_scale,
   output logic                           rsp_a_out_negative,
   output logic [dsa_pkg::LOW_BITS-1:0]   rsp_b_out_low,
   output logic [dsa_pkg::HIGH_BITS-1:0]  rsp_b_out_high,
   output logic [dsa_pkg::SCALE_BITS-1:0] rsp_b_out_scale,
   output logic                           rsp_b_out_negative
);
   import dsa_pkg::*;

   localparam int LIMB_CNT = (MANT_BITS + LIMB_BITS - 1) / LIMB_BITS;
   localparam int PAD_BITS = LIMB_CNT * LIMB_BITS;
   localparam int IDX_BITS = (LIMB_CNT > 1) ? $clog2(LIMB_CNT) : 1;

   ctl_type               ctl;
   stat_type              stat;
   logic [IDX_BITS-1:0]   limb_idx;
   logic                  accept;
   logic                  a_is_up;
   logic [SCALE_BITS-1:0] load_count;
   logic [MANT_BITS-1:0]  a_load;
   logic [MANT_BITS-1:0]  b_load;

   logic [MANT_BITS-1:0]  up_ff, up_in;
   logic [MANT_BITS-1:0]  down_ff, down_in;
   logic [SCALE_BITS-1:0] up_scale_ff, up_scale_in;
   logic [SCALE_BITS-1:0] down_scale_ff, down_scale_in;
   logic                  a_is_up_ff, a_is_up_in;
   logic                  a_neg_ff, a_neg_in;
   logic                  b_neg_ff, b_neg_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;

   logic [MANT_BITS-1:0]  alu_operand;
   logic [MANT_BITS+3:0]  alu_sum;
   logic [LIMB_BITS-1:0]  alu_limb;
   logic [REM_BITS-1:0]   alu_rem_in;
   logic [LIMB_BITS-1:0]  alu_quot;
   logic [REM_BITS-1:0]   alu_rem_out;
   logic [PAD_BITS-1:0]   down_pad;
   logic [PAD_BITS-1:0]   down_pad_new;

   logic [IN_MANT_BITS-1:0] a_res;
   logic [IN_MANT_BITS-1:0] b_res;

   assign accept     = start && !ctl.busy;
   assign a_is_up    = (req_a_scale < req_b_scale);
   assign load_count = a_is_up ? (req_b_scale - req_a_scale) : (req_a_scale - req_b_scale);
   assign a_load     = MANT_BITS'({req_a_mant_high, req_a_mant_low});
   assign b_load     = MANT_BITS'({req_b_mant_high, req_b_mant_low});

   dsa_seq #(
      .MANT_BITS (MANT_BITS),
      .LIMB_CNT  (LIMB_CNT),
      .IDX_BITS  (IDX_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .load_count (load_count),
      .stat       (stat),
      .ctl        (ctl),
      .limb_idx   (limb_idx)
   );

   assign alu_operand = ctl.sel_inc ? down_ff : up_ff;
   assign down_pad    = PAD_BITS'(down_ff);
   assign alu_limb    = down_pad[limb_idx*LIMB_BITS +: LIMB_BITS];
   assign alu_rem_in  = ctl.div_first ? '0 : rem_ff;

   dsa_alu #(
      .MANT_BITS (MANT_BITS)
   ) u_alu (
      .sel_inc (ctl.sel_inc),
      .operand (alu_operand),
      .limb    (alu_limb),
      .rem_in  (alu_rem_in),
      .sum     (alu_sum),
      .quot    (alu_quot),
      .rem_out (alu_rem_out)
   );

   always_comb begin
      down_pad_new = down_pad;
      down_pad_new[limb_idx*LIMB_BITS +: LIMB_BITS] = alu_quot;
   end

   assign stat.up_zero   = (up_ff == '0);
   assign stat.up_stop   = (|up_ff[MANT_BITS-1 -: 3]) || (|alu_sum[MANT_BITS+3 -: 4]);
   assign stat.down_zero = (down_ff == '0);
   assign stat.rem       = alu_rem_out;

   always_comb begin
      up_in         = up_ff;
      down_in       = down_ff;
      up_scale_in   = up_scale_ff;
      down_scale_in = down_scale_ff;
      a_is_up_in    = a_is_up_ff;
      a_neg_in      = a_neg_ff;
      b_neg_in      = b_neg_ff;
      rem_in        = rem_ff;
      case (ctl.op)
         OP_LOAD: begin
            a_is_up_in    = a_is_up;
            up_in         = a_is_up ? a_load : b_load;
            down_in       = a_is_up ? b_load : a_load;
            up_scale_in   = a_is_up ? req_a_scale : req_b_scale;
            down_scale_in = a_is_up ? req_b_scale : req_a_scale;
            a_neg_in      = req_a_negative;
            b_neg_in      = req_b_negative;
         end
         OP_MUL: begin
            up_in       = alu_sum[MANT_BITS-1:0];
            up_scale_in = up_scale_ff + SCALE_BITS'(1);
         end
         OP_UP_SKIP:   up_scale_in   = up_scale_ff + ctl.count;
         OP_DOWN_SKIP: down_scale_in = down_scale_ff - ctl.count;
         OP_DIV: begin
            down_in = down_pad_new[MANT_BITS-1:0];
            rem_in  = alu_rem_out;
            if (ctl.div_last) down_scale_in = down_scale_ff - SCALE_BITS'(1);
         end
         OP_INC: down_in = alu_sum[MANT_BITS-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      up_ff         <= up_in;
      down_ff       <= down_in;
      up_scale_ff   <= up_scale_in;
      down_scale_ff <= down_scale_in;
      a_is_up_ff    <= a_is_up_in;
      a_neg_ff      <= a_neg_in;
      b_neg_ff      <= b_neg_in;
      rem_ff        <= rem_in;
   end

   assign a_res = IN_MANT_BITS'(a_is_up_ff ? up_ff : down_ff);
   assign b_res = IN_MANT_BITS'(a_is_up_ff ? down_ff : up_ff);

   assign busy               = ctl.busy;
   assign rsp_valid          = ctl.done;
   assign rsp_a_out_low      = a_res[LOW_BITS-1:0];
   assign rsp_a_out_high     = a_res[IN_MANT_BITS-1:LOW_BITS];
   assign rsp_a_out_scale    = a_is_up_ff ? up_scale_ff : down_scale_ff;
   assign rsp_a_out_negative = a_neg_ff;
   assign rsp_b_out_low      = b_res[LOW_BITS-1:0];
   assign rsp_b_out_high     = b_res[IN_MANT_BITS-1:LOW_BITS];
   assign rsp_b_out_scale    = a_is_up_ff ? down_scale_ff : up_scale_ff;
   assign rsp_b_out_negative = b_neg_ff;

endmodule
